/* hdl/trem_pkg.sv */
// ----------------------------------------------------------------------------
// trem_pkg: shared types and constants of the traffic rate meter
// Widths, reset values, opcodes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package trem_pkg;

    localparam int NUM_FRAME_TYPES = 32;
    localparam int NUM_FIXED_TYPES = 3;
    localparam int FRACTION_BITS   = 10;

    localparam int CNT_W      = 48;
    localparam int ALU_W      = 58;   // 48-bit count times 1000
    localparam int PERIOD_W   = 20;
    localparam int SHIFT_W    = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 20;
    localparam int DIV_STEPS  = ALU_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // x * 1000 = (x << 10) - (x << 4) - (x << 3)
    localparam int MUL_SH_HI = 10;
    localparam int MUL_SH_A  = 4;
    localparam int MUL_SH_B  = 3;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);
    localparam logic [SHIFT_W-1:0]  SHIFT_RESET  = SHIFT_W'(4);
    localparam logic [CNT_W-1:0]    CNT_MAX      = '1;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_TICK = 2'd1,
        OP_READ = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_MS = CFG_IDX_W'(0),
        CFG_AVG_SHIFT = CFG_IDX_W'(1)
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_READ,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_AVG1,
        S_AVG2,
        S_WR
    } t_state;

endpackage

/* hdl/trem_alu.sv */
// ----------------------------------------------------------------------------
// trem_alu: shared adder/subtractor
// One wide add or subtract with carry/borrow out, used by the add and tick steps.
// ----------------------------------------------------------------------------
module trem_alu (
    input  logic                        i_sub,
    input  logic [trem_pkg::ALU_W-1:0]  i_a,
    input  logic [trem_pkg::ALU_W-1:0]  i_b,
    output logic [trem_pkg::ALU_W:0]    o_res
);

    always_comb begin
        if (i_sub) begin
            o_res = {1'b0, i_a} - {1'b0, i_b};
        end else begin
            o_res = {1'b0, i_a} + {1'b0, i_b};
        end
    end

endmodule

/* hdl/traffic_rate_ewma_meter.sv */
// ----------------------------------------------------------------------------
// traffic_rate_ewma_meter: per-direction, per-category byte rate meter
// Add and read pass through S_ADD and S_READ; a read result strobes in S_READ.
// A tick walks all 2 * categories counters (70 at defaults) through multiply,
// a bit-serial divide of 58 steps on the shared adder, average update, write.
// One transaction at a time; busy stays high until it is done; no result stall.
// Synchronous reset clears all counters (valid bits) and loads register defaults.
// ----------------------------------------------------------------------------
module traffic_rate_ewma_meter #(
    parameter int NUM_FRAME_TYPES = trem_pkg::NUM_FRAME_TYPES,
    parameter int NUM_FIXED_TYPES = trem_pkg::NUM_FIXED_TYPES,
    parameter int FRACTION_BITS   = trem_pkg::FRACTION_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_opcode,
    input  logic                                i_direction,
    input  logic [5:0]                          i_category,
    input  logic [15:0]                         i_byte_count,
    output logic                                o_result_valid,
    output logic [trem_pkg::CNT_W-1:0]          o_interval_rate,
    output logic [trem_pkg::CNT_W-1:0]          o_average_rate,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [trem_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [trem_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int NCAT  = NUM_FIXED_TYPES + NUM_FRAME_TYPES;
    localparam int NCNT  = 2 * NCAT;
    localparam int IDX_W = $clog2(NCNT);
    localparam int CW    = trem_pkg::CNT_W;
    localparam int AW    = trem_pkg::ALU_W;
    localparam int PW    = trem_pkg::PERIOD_W;
    localparam int SW    = trem_pkg::SHIFT_W;
    localparam int STW   = trem_pkg::STEP_W;

    trem_pkg::t_state r_state, n_state;

    logic [PW-1:0]    r_period_ms;
    logic [SW-1:0]    r_avg_shift;
    logic [PW-1:0]    r_div;
    logic [NCNT-1:0]  r_acc_vld;
    logic [NCNT-1:0]  r_rv_vld;

    logic [IDX_W-1:0] r_idx;
    logic             r_cat_ok;
    logic [15:0]      r_bytes;
    logic [IDX_W-1:0] r_k;
    logic [AW-1:0]    r_num;
    logic [PW-1:0]    r_rem;
    logic [STW-1:0]   r_step;
    logic [CW-1:0]    r_accw;
    logic [CW-1:0]    r_rate;
    logic [CW-1:0]    r_avg;

    logic [CW-1:0]    r_acc_mem  [NCNT];
    logic [CW-1:0]    r_rate_mem [NCNT];
    logic [CW-1:0]    r_avg_mem  [NCNT];
    logic [CW-1:0]    r_acc_rd;
    logic [CW-1:0]    r_rate_rd;
    logic [CW-1:0]    r_avg_rd;
    logic             r_acc_ok;
    logic             r_rv_ok;

    logic             w_in_ok;
    logic [IDX_W-1:0] w_in_idx;
    logic [IDX_W-1:0] w_rd_addr;
    logic             w_last;
    logic [CW-1:0]    w_acc_eff;
    logic [CW-1:0]    w_avg_eff;
    logic [CW-1:0]    w_bytes_fx;
    logic [PW-1:0]    w_divisor;
    logic [PW:0]      w_rem_sh;
    logic             w_alu_sub;
    logic [AW-1:0]    w_alu_a;
    logic [AW-1:0]    w_alu_b;
    logic [AW:0]      w_alu_res;
    logic             w_borrow;
    logic [CW-1:0]    w_sum_sat;
    logic [CW-1:0]    w_quot_sat;

    assign w_in_ok    = int'(i_category) < NCAT;
    assign w_in_idx   = w_in_ok ? IDX_W'((i_direction ? NCAT : 0) + int'(i_category))
                                : '0;
    assign w_last     = (r_k == IDX_W'(NCNT - 1));
    assign w_acc_eff  = r_acc_ok ? r_acc_rd : '0;
    assign w_avg_eff  = r_rv_ok ? r_avg_rd : '0;
    assign w_bytes_fx = CW'(r_bytes) << FRACTION_BITS;
    assign w_divisor  = (r_div == '0) ? PW'(1) : r_div;
    assign w_rem_sh   = {r_rem, r_num[AW-1]};
    assign w_borrow   = w_alu_res[AW];
    assign w_sum_sat  = (|w_alu_res[AW:CW]) ? trem_pkg::CNT_MAX : w_alu_res[CW-1:0];
    assign w_quot_sat = (|r_num[AW-1:CW]) ? trem_pkg::CNT_MAX : r_num[CW-1:0];
    assign o_cfg_ready = 1'b1;

    trem_alu u_alu (
        .i_sub (w_alu_sub),
        .i_a   (w_alu_a),
        .i_b   (w_alu_b),
        .o_res (w_alu_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            trem_pkg::S_IDLE: begin
                if (start) begin
                    case (trem_pkg::t_opcode'(i_opcode))
                        trem_pkg::OP_ADD:  n_state = trem_pkg::S_ADD;
                        trem_pkg::OP_TICK: n_state = trem_pkg::S_MUL1;
                        trem_pkg::OP_READ: n_state = trem_pkg::S_READ;
                        default:           n_state = trem_pkg::S_IDLE;
                    endcase
                end
            end
            trem_pkg::S_ADD:  n_state = trem_pkg::S_IDLE;
            trem_pkg::S_READ: n_state = trem_pkg::S_IDLE;
            trem_pkg::S_MUL1: n_state = trem_pkg::S_MUL2;
            trem_pkg::S_MUL2: n_state = trem_pkg::S_DIV;
            trem_pkg::S_DIV: begin
                if (r_step == '0) begin
                    n_state = trem_pkg::S_AVG1;
                end
            end
            trem_pkg::S_AVG1: n_state = trem_pkg::S_AVG2;
            trem_pkg::S_AVG2: n_state = trem_pkg::S_WR;
            trem_pkg::S_WR:   n_state = w_last ? trem_pkg::S_IDLE : trem_pkg::S_MUL1;
            default:          n_state = trem_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        busy            = (r_state != trem_pkg::S_IDLE);
        o_result_valid  = (r_state == trem_pkg::S_READ);
        o_interval_rate = (r_cat_ok && r_rv_ok) ? r_rate_rd : '0;
        o_average_rate  = (r_cat_ok && r_rv_ok) ? r_avg_rd : '0;

        w_alu_sub = 1'b0;
        w_alu_a   = '0;
        w_alu_b   = '0;
        w_rd_addr = r_idx;
        case (r_state)
            trem_pkg::S_IDLE: begin
                w_rd_addr = (trem_pkg::t_opcode'(i_opcode) == trem_pkg::OP_TICK) ? '0
                                                                                 : w_in_idx;
            end
            trem_pkg::S_ADD: begin
                w_alu_a = AW'(w_acc_eff);
                w_alu_b = AW'(w_bytes_fx);
            end
            trem_pkg::S_MUL1: begin
                w_rd_addr = r_k;
                w_alu_sub = 1'b1;
                w_alu_a   = AW'(w_acc_eff) << trem_pkg::MUL_SH_HI;
                w_alu_b   = AW'(w_acc_eff) << trem_pkg::MUL_SH_A;
            end
            trem_pkg::S_MUL2: begin
                w_rd_addr = r_k;
                w_alu_sub = 1'b1;
                w_alu_a   = r_num;
                w_alu_b   = AW'(r_accw) << trem_pkg::MUL_SH_B;
            end
            trem_pkg::S_DIV: begin
                w_rd_addr = r_k;
                w_alu_sub = 1'b1;
                w_alu_a   = AW'(w_rem_sh);
                w_alu_b   = AW'(w_divisor);
            end
            trem_pkg::S_AVG1: begin
                w_rd_addr = r_k;
                w_alu_sub = 1'b1;
                w_alu_a   = AW'(r_avg);
                w_alu_b   = AW'(r_avg >> r_avg_shift);
            end
            trem_pkg::S_AVG2: begin
                w_rd_addr = r_k;
                w_alu_a   = AW'(r_avg);
                w_alu_b   = AW'(r_rate >> r_avg_shift);
            end
            trem_pkg::S_WR: begin
                w_rd_addr = w_last ? '0 : r_k + IDX_W'(1);
            end
            default: begin
                w_rd_addr = r_idx;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= trem_pkg::S_IDLE;
            r_period_ms <= trem_pkg::PERIOD_RESET;
            r_avg_shift <= trem_pkg::SHIFT_RESET;
            r_div       <= trem_pkg::PERIOD_RESET;
            r_acc_vld   <= '0;
            r_rv_vld    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (trem_pkg::t_cfg_idx'(i_cfg_index))
                    trem_pkg::CFG_PERIOD_MS: r_period_ms <= i_cfg_data[PW-1:0];
                    trem_pkg::CFG_AVG_SHIFT: r_avg_shift <= i_cfg_data[SW-1:0];
                    default: ;
                endcase
            end
            if (r_state == trem_pkg::S_ADD && r_cat_ok) begin
                r_acc_vld[r_idx] <= 1'b1;
            end
            if (r_state == trem_pkg::S_WR) begin
                r_acc_vld[r_k] <= 1'b0;
                r_rv_vld[r_k]  <= 1'b1;
                if (w_last) begin
                    r_div <= r_period_ms;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            trem_pkg::S_IDLE: begin
                if (start) begin
                    r_idx    <= w_in_idx;
                    r_cat_ok <= w_in_ok;
                    r_bytes  <= i_byte_count;
                    r_k      <= '0;
                end
            end
            trem_pkg::S_MUL1: begin
                r_num  <= w_alu_res[AW-1:0];
                r_accw <= w_acc_eff;
                r_avg  <= w_avg_eff;
            end
            trem_pkg::S_MUL2: begin
                r_num  <= w_alu_res[AW-1:0];
                r_rem  <= '0;
                r_step <= STW'(trem_pkg::DIV_STEPS - 1);
            end
            trem_pkg::S_DIV: begin
                r_rem  <= w_borrow ? w_rem_sh[PW-1:0] : w_alu_res[PW-1:0];
                r_num  <= {r_num[AW-2:0], ~w_borrow};
                r_step <= r_step - STW'(1);
            end
            trem_pkg::S_AVG1: begin
                r_rate <= w_quot_sat;
                r_avg  <= w_alu_res[CW-1:0];
            end
            trem_pkg::S_AVG2: begin
                r_avg <= w_sum_sat;
            end
            trem_pkg::S_WR: begin
                r_k <= r_k + IDX_W'(1);
            end
            default: ;
        endcase
    end

    // counter memories
    always_ff @(posedge i_clk) begin
        r_acc_rd  <= r_acc_mem[w_rd_addr];
        r_rate_rd <= r_rate_mem[w_rd_addr];
        r_avg_rd  <= r_avg_mem[w_rd_addr];
        r_acc_ok  <= r_acc_vld[w_rd_addr];
        r_rv_ok   <= r_rv_vld[w_rd_addr];
        if (r_state == trem_pkg::S_ADD && r_cat_ok) begin
            r_acc_mem[r_idx] <= w_sum_sat;
        end
        if (r_state == trem_pkg::S_WR) begin
            r_rate_mem[r_k] <= r_rate;
            r_avg_mem[r_k]  <= r_avg;
        end
    end

endmodule

/* hdl/trem_checker.sv */
// ----------------------------------------------------------------------------
// trem_checker: port-level checks of the traffic rate meter
// Sequencing of add, read and tick transactions as seen on the top-level ports.
// ----------------------------------------------------------------------------
module trem_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_opcode,
    input logic       o_result_valid
);

    logic w_acc;

    assign w_acc = start && !busy;

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_opcode == trem_pkg::OP_READ) |=> (busy && o_result_valid) ##1 !busy)
        else $error("read transaction did not return its result on time");

    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(w_acc) && $past(i_opcode) == trem_pkg::OP_READ))
        else $error("result strobe without a read transaction");

    a_add_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_opcode == trem_pkg::OP_ADD) |=> ##1 (!busy && !o_result_valid))
        else $error("add transaction not finished in two cycles");

    a_tick_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_opcode == trem_pkg::OP_TICK) |=> busy ##1 busy ##1 busy)
        else $error("tick transaction ended early");

endmodule

bind traffic_rate_ewma_meter trem_checker u_trem_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_opcode       (i_opcode),
    .o_result_valid (o_result_valid)
);
